// ----- design/ocpd_pkg.sv -----
`default_nettype none
package ocpd_pkg;

  localparam int UV_W      = 32;
  localparam int DIFF_W    = UV_W + 1;
  localparam int TICKS_W   = 16;
  localparam int SETUP_W   = TICKS_W + 1;
  localparam int CFG_IDX_W = 2;

  typedef logic signed [UV_W-1:0]   uv_t;
  typedef logic signed [DIFF_W-1:0] uv_diff_t;

  // drop tests are active only above this magnitude
  localparam uv_diff_t DROP_ENABLE_UV = 33'sd1000;

  typedef enum logic [4:0] {
    MODE_IDLE   = 5'b00001,
    MODE_SETUP  = 5'b00010,
    MODE_PROBE  = 5'b00100,
    MODE_SENSED = 5'b01000,
    MODE_DONE   = 5'b10000
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_LIMIT = 2'd0,
    REG_DROP_LIMIT  = 2'd1,
    REG_SETUP_TICKS = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    uv_t                start_limit_uv;
    uv_t                drop_limit_uv;
    logic [TICKS_W-1:0] setup_ticks;
  } cfg_t;

  typedef struct packed {
    uv_t  voltage_uv;
    logic read_error;
    logic probe_enable;
  } sample_t;

endpackage
`default_nettype wire

// ----- design/ocpd_if.sv -----
`default_nettype none
interface ocpd_in_if import ocpd_pkg::*; ();
  logic valid;
  logic ready;
  uv_t  voltage_uv;
  logic read_error;
  logic probe_enable;

  modport source (output valid, output voltage_uv, output read_error, output probe_enable,
                  input ready);
  modport sink (input valid, input voltage_uv, input read_error, input probe_enable,
                output ready);
endinterface

interface ocpd_out_if ();
  logic valid;
  logic ready;
  logic contact_sensed;

  modport source (output valid, output contact_sensed, input ready);
  modport sink (input valid, input contact_sensed, output ready);
endinterface

interface ocpd_cfg_if import ocpd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [UV_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- design/ohmic_contact_probe_detector.sv -----
// path: an accepted transaction is captured in the input register, then moves to the
//   result register when the output side is not stalled
// throughput: one transaction per clock unless the output stalls; the mode update is
//   combinational logic on the input register; a stall also holds a full input register
// reset: synchronous active-low rst_n returns to idle with counters, window fill and
//   configuration cleared; no clearing pass, transactions are taken right after reset
`default_nettype none
module ohmic_contact_probe_detector import ocpd_pkg::*; #(
  parameter int WINDOW_DEPTH  = 3,
  parameter int PROBE_TIMEOUT = 30000,
  parameter int HOLD_TICKS    = 100
) (
  input  wire         clk,
  input  wire         rst_n,
  ocpd_in_if.sink     in_if,
  ocpd_out_if.source  out_if,
  ocpd_cfg_if.sink    cfg_if
);

  cfg_t    cfg;
  logic    s1_valid;
  sample_t s1_sample;
  logic    advance;

  ocpd_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  ocpd_in_stage u_in_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .advance   (advance),
    .s1_valid  (s1_valid),
    .s1_sample (s1_sample)
  );

  ocpd_core #(
    .WINDOW_DEPTH  (WINDOW_DEPTH),
    .PROBE_TIMEOUT (PROBE_TIMEOUT),
    .HOLD_TICKS    (HOLD_TICKS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .s1_valid  (s1_valid),
    .s1_sample (s1_sample),
    .advance   (advance),
    .out_if    (out_if)
  );

endmodule
`default_nettype wire

// ----- design/ocpd_cfg_regs.sv -----
`default_nettype none
module ocpd_cfg_regs import ocpd_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  ocpd_cfg_if.sink    cfg_if,
  output cfg_t        cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_if.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_if.valid) begin
      case (cfg_reg_t'(cfg_if.index))
        REG_START_LIMIT: cfg_nxt.start_limit_uv = uv_t'(cfg_if.data);
        REG_DROP_LIMIT:  cfg_nxt.drop_limit_uv  = uv_t'(cfg_if.data);
        REG_SETUP_TICKS: cfg_nxt.setup_ticks    = cfg_if.data[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- design/ocpd_in_stage.sv -----
`default_nettype none
module ocpd_in_stage import ocpd_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  ocpd_in_if.sink     in_if,
  input  wire         advance,
  output logic        s1_valid,
  output sample_t     s1_sample
);

  logic    s1_valid_r;
  logic    s1_valid_nxt;
  sample_t s1_sample_r;
  logic    take;

  assign in_if.ready = !s1_valid_r || advance;
  assign take        = in_if.valid && in_if.ready;
  assign s1_valid    = s1_valid_r;
  assign s1_sample   = s1_sample_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_sample_r <= '{voltage_uv: in_if.voltage_uv, read_error: in_if.read_error,
                       probe_enable: in_if.probe_enable};
    end
  end

endmodule
`default_nettype wire

// ----- design/ocpd_core.sv -----
`default_nettype none
module ocpd_core import ocpd_pkg::*; #(
  parameter int WINDOW_DEPTH  = 3,
  parameter int PROBE_TIMEOUT = 30000,
  parameter int HOLD_TICKS    = 100
) (
  input  wire         clk,
  input  wire         rst_n,
  input  var cfg_t    cfg,
  input  wire         s1_valid,
  input  var sample_t s1_sample,
  output logic        advance,
  ocpd_out_if.source  out_if
);

  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int IDX_W = $clog2(WINDOW_DEPTH);
  localparam int PC_W  = $clog2(PROBE_TIMEOUT + 2);
  localparam int HC_W  = $clog2(HOLD_TICKS + 1);

  mode_t              mode_r, mode_nxt;
  logic [SETUP_W-1:0] setup_cnt_r, setup_cnt_nxt;
  logic [PC_W-1:0]    probe_cnt_r, probe_cnt_nxt;
  logic [HC_W-1:0]    hold_cnt_r, hold_cnt_nxt;
  uv_t                reference_r, reference_nxt;
  uv_t                previous_r, previous_nxt;
  logic [CNT_W-1:0]   recent_cnt_r, recent_cnt_nxt;
  uv_t                win_r [WINDOW_DEPTH];
  logic               push;
  logic               out_valid_r, out_valid_nxt;
  logic               out_sensed_r, sensed;

  logic               fire;
  logic [IDX_W-1:0]   oldest_idx;
  uv_t                oldest;
  uv_diff_t           v_x, start_x, drop_x, ref_x, prev_x, old_x;
  logic               drops, hit;

  assign advance = !out_valid_r || out_if.ready;
  assign fire    = s1_valid && advance;

  assign out_if.valid          = out_valid_r;
  assign out_if.contact_sensed = out_sensed_r;

  // oldest held sample once the current one has been pushed
  always_comb begin
    if (recent_cnt_r >= CNT_W'(WINDOW_DEPTH - 1)) begin
      oldest_idx = IDX_W'(WINDOW_DEPTH - 1);
    end else begin
      oldest_idx = recent_cnt_r[IDX_W-1:0];
    end
    if (oldest_idx == '0) begin
      oldest = s1_sample.voltage_uv;
    end else begin
      oldest = win_r[IDX_W'(oldest_idx - 1'b1)];
    end
  end

  always_comb begin
    v_x     = $signed({s1_sample.voltage_uv[UV_W-1], s1_sample.voltage_uv});
    start_x = $signed({cfg.start_limit_uv[UV_W-1], cfg.start_limit_uv});
    drop_x  = $signed({cfg.drop_limit_uv[UV_W-1], cfg.drop_limit_uv});
    ref_x   = $signed({reference_r[UV_W-1], reference_r});
    prev_x  = $signed({previous_r[UV_W-1], previous_r});
    old_x   = $signed({oldest[UV_W-1], oldest});
    drops   = (drop_x > DROP_ENABLE_UV) || (drop_x < -DROP_ENABLE_UV);
    hit     = (v_x <= start_x) ||
              (drops && ((ref_x - v_x) >= drop_x)) ||
              (drops && ((prev_x - v_x) >= drop_x)) ||
              (drops && ((old_x - v_x) > drop_x));
  end

  always_comb begin
    mode_nxt       = mode_r;
    setup_cnt_nxt  = setup_cnt_r;
    probe_cnt_nxt  = probe_cnt_r;
    hold_cnt_nxt   = hold_cnt_r;
    reference_nxt  = reference_r;
    previous_nxt   = previous_r;
    recent_cnt_nxt = recent_cnt_r;
    push           = 1'b0;
    sensed         = 1'b0;

    if (fire) begin
      if (!s1_sample.probe_enable || s1_sample.read_error) begin
        mode_nxt = MODE_IDLE;
      end else begin
        case (mode_r)
          MODE_IDLE: begin
            if (v_x > start_x) begin
              mode_nxt       = MODE_SETUP;
              setup_cnt_nxt  = '0;
              recent_cnt_nxt = '0;
            end
          end
          MODE_SETUP: begin
            if (setup_cnt_r != '1) begin
              setup_cnt_nxt = setup_cnt_r + 1'b1;
            end
            if (setup_cnt_r > {1'b0, cfg.setup_ticks}) begin
              mode_nxt      = MODE_PROBE;
              probe_cnt_nxt = '0;
              previous_nxt  = '0;
              reference_nxt = s1_sample.voltage_uv;
            end
          end
          MODE_PROBE: begin
            push = 1'b1;
            if (recent_cnt_r < CNT_W'(WINDOW_DEPTH)) begin
              recent_cnt_nxt = recent_cnt_r + 1'b1;
            end
            // count saturates one past the timeout, which is all the compare needs
            if (probe_cnt_r <= PC_W'(PROBE_TIMEOUT)) begin
              probe_cnt_nxt = probe_cnt_r + 1'b1;
            end
            if (probe_cnt_r > PC_W'(PROBE_TIMEOUT)) begin
              mode_nxt = MODE_IDLE;
            end else begin
              if (hit) begin
                sensed       = 1'b1;
                hold_cnt_nxt = '0;
                mode_nxt     = MODE_SENSED;
              end
              previous_nxt = s1_sample.voltage_uv;
            end
          end
          MODE_SENSED: begin
            if (hold_cnt_r >= HC_W'(HOLD_TICKS)) begin
              mode_nxt = MODE_DONE;
            end else begin
              sensed       = 1'b1;
              hold_cnt_nxt = hold_cnt_r + 1'b1;
            end
          end
          MODE_DONE: begin
            sensed = 1'b0;
          end
          default: begin
            mode_nxt = MODE_IDLE;
          end
        endcase
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_IDLE;
      setup_cnt_r  <= '0;
      probe_cnt_r  <= '0;
      hold_cnt_r   <= '0;
      reference_r  <= '0;
      previous_r   <= '0;
      recent_cnt_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      mode_r       <= mode_nxt;
      setup_cnt_r  <= setup_cnt_nxt;
      probe_cnt_r  <= probe_cnt_nxt;
      hold_cnt_r   <= hold_cnt_nxt;
      reference_r  <= reference_nxt;
      previous_r   <= previous_nxt;
      recent_cnt_r <= recent_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // sample window, newest first
  always_ff @(posedge clk) begin
    if (push) begin
      win_r[0] <= s1_sample.voltage_uv;
      for (int i = 1; i < WINDOW_DEPTH; i++) begin
        win_r[i] <= win_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_sensed_r <= sensed;
    end
  end

endmodule
`default_nettype wire

// ----- design/ocpd_checker.sv -----
`default_nettype none
module ocpd_checker (
  input wire clk,
  input wire rst_n,
  input wire in_valid,
  input wire in_ready,
  input wire out_valid,
  input wire out_ready,
  input wire contact_sensed
);

  // result held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(contact_sensed))
    else $error("result changed or dropped while stalled");

  // an accepted transaction always shows a result once through the input and result registers
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> ##2 out_valid)
    else $error("no result after accepted transaction");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // with a result stalled and a transaction already buffered, input must back off
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && out_valid && !out_ready |=> !out_ready |-> !in_ready)
    else $error("input accepted with both stages full");

endmodule

bind ohmic_contact_probe_detector ocpd_checker u_ocpd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_if.valid),
  .in_ready       (in_if.ready),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .contact_sensed (out_if.contact_sensed)
);
`default_nettype wire
